// ----- design/aboap_pkg.sv -----
`timescale 1ns / 1ps

package aboap_pkg;

	// CORDIC x/y datapath width; holds a 17-bit vector times 65536 plus gain
	localparam int XY_W = 36;

	localparam int TABLE_LEN = 24;
	localparam int IDX_W = 5;

	// CORDIC gain compensation, Q0.30, truncated
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	localparam int RADIUS_W = 10;
	localparam int DEADZONE_W = 15;
	localparam int WR_DATA_W = 15;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd75;
	localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = 15'd128;

	// register indexes
	localparam logic [0:0] REG_ORBIT_RADIUS = 1'b0;
	localparam logic [0:0] REG_STICK_DEADZONE = 1'b1;

	typedef struct packed {
		logic rotate;              // 1: rotation mode, 0: vectoring mode
		logic [IDX_W-1:0] idx;     // iteration number, also the shift amount
	} cordic_ctl_t;

	// arctangent of 2^-i, 2^32 units per turn
	function automatic logic [31:0] atan_turn32(input logic [IDX_W-1:0] i);
		logic [31:0] t;
		unique case (i)
			5'd0: t = 32'h20000000;
			5'd1: t = 32'h12E4051E;
			5'd2: t = 32'h09FB385B;
			5'd3: t = 32'h051111D4;
			5'd4: t = 32'h028B0D43;
			5'd5: t = 32'h0145D7E1;
			5'd6: t = 32'h00A2F61E;
			5'd7: t = 32'h00517C55;
			5'd8: t = 32'h0028BE53;
			5'd9: t = 32'h00145F2F;
			5'd10: t = 32'h000A2F98;
			5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6;
			5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2FA;
			5'd15: t = 32'h0000517D;
			5'd16: t = 32'h000028BE;
			5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30;
			5'd19: t = 32'h00000518;
			5'd20: t = 32'h0000028C;
			5'd21: t = 32'h00000146;
			5'd22: t = 32'h000000A3;
			5'd23: t = 32'h00000051;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

endpackage

// ----- design/aboap_cordic_unit.sv -----
`timescale 1ns / 1ps

module aboap_cordic_unit #(
	parameter int ANGLE_BITS = 16
) (
	input  aboap_pkg::cordic_ctl_t            ctl,
	input  logic signed [aboap_pkg::XY_W-1:0] x,
	input  logic signed [aboap_pkg::XY_W-1:0] y,
	input  logic signed [ANGLE_BITS+1:0]      z,
	output logic signed [aboap_pkg::XY_W-1:0] x_nx,
	output logic signed [aboap_pkg::XY_W-1:0] y_nx,
	output logic signed [ANGLE_BITS+1:0]      z_nx
);
	import aboap_pkg::*;

	localparam int ZW = ANGLE_BITS + 2;

	logic [32:0] ang_raw;
	logic signed [ZW-1:0] ang;
	logic signed [XY_W-1:0] xs, ys;
	logic neg;

	// table angle rounded to the accumulator scale
	assign ang_raw = {1'b0, atan_turn32(ctl.idx)} + (33'd1 << (31 - ANGLE_BITS));
	assign ang = ZW'(ang_raw >> (32 - ANGLE_BITS));

	assign xs = x >>> ctl.idx;
	assign ys = y >>> ctl.idx;

	// vectoring drives y to zero, rotation drives z to zero
	assign neg = ctl.rotate ? ~z[ZW-1] : y[XY_W-1];

	always_comb begin
		if (neg) begin
			x_nx = x - ys;
			y_nx = y + xs;
			z_nx = z - ang;
		end else begin
			x_nx = x + ys;
			y_nx = y - xs;
			z_nx = z + ang;
		end
	end

endmodule

// ----- design/aim_bearing_and_orbit_point.sv -----
`timescale 1ns / 1ps
// A request runs S_LOAD, the vectoring pass (S_VEC, S_BEAR), the rotation pass (S_ROTLOAD,
// S_ROT), S_FIN and S_OUT; the vectoring pass is skipped when the stick is zero or the
// horizontal component is zero. A new request is taken only in S_IDLE, once the last one
// has left S_OUT; the single CORDIC add/shift unit runs the vectoring, then the rotation pass.
// The output register frees the input side; a request waits in S_OUT until the last result is taken.
// Reset (arst_n low, asynchronous): idle, no result, stored bearing 0, radius 75, deadzone 128.
module aim_bearing_and_orbit_point #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// point_x[12:0] point_y[25:13] stick_u[41:26] stick_v[57:42]
	// center_x[69:58] center_y[81:70], zero pad [87:82]
	input  logic [87:0] s_tdata,
	// action[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// bearing[15:0] bearing_degrees[30:16] place_x[52:31] place_y[74:53], zero pad [79:75]
	output logic [79:0] m_tdata,
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [aboap_pkg::WR_DATA_W-1:0] wr_data
);
	import aboap_pkg::*;

	localparam int ZW = ANGLE_BITS + 2;
	localparam int N_STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int CW = $clog2(N_STEPS);

	localparam logic signed [ZW-1:0] Z_FULL = ZW'(1 << ANGLE_BITS);
	localparam logic signed [ZW-1:0] Z_HALF = ZW'(1 << (ANGLE_BITS - 1));
	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(1 << (ANGLE_BITS - 2));

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_LOAD    = 3'd1;
	localparam logic [2:0] S_VEC     = 3'd2;
	localparam logic [2:0] S_BEAR    = 3'd3;
	localparam logic [2:0] S_ROTLOAD = 3'd4;
	localparam logic [2:0] S_ROT     = 3'd5;
	localparam logic [2:0] S_FIN     = 3'd6;
	localparam logic [2:0] S_OUT     = 3'd7;

	logic [2:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [DEADZONE_W-1:0] deadzone_q;
	logic [15:0] last_q;

	logic signed [16:0] dx_q, up_q;
	logic keep_q;
	logic [11:0] cx_q, cy_q;
	logic [39:0] prod_q;
	logic [15:0] bear_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic rneg_q;
	logic [21:0] c8_q, s8_q;

	logic m_tvalid_q;
	logic [15:0] out_bear_q;
	logic [14:0] out_deg_q;
	logic [21:0] out_px_q, out_py_q;

	// input fields
	logic signed [12:0] point_x, point_y;
	logic [15:0] stick_u, stick_v;
	logic [11:0] center_x, center_y;
	assign point_x  = s_tdata[12:0];
	assign point_y  = s_tdata[25:13];
	assign stick_u  = s_tdata[41:26];
	assign stick_v  = s_tdata[57:42];
	assign center_x = s_tdata[69:58];
	assign center_y = s_tdata[81:70];

	// one-sided deadzone: only small positive values are cleared
	logic [15:0] u_f, v_f;
	logic u_clr, v_clr;
	assign u_clr = ~stick_u[15] && (stick_u != 16'd0) && (stick_u[14:0] < deadzone_q);
	assign v_clr = ~stick_v[15] && (stick_v != 16'd0) && (stick_v[14:0] < deadzone_q);
	assign u_f = u_clr ? 16'd0 : stick_u;
	assign v_f = v_clr ? 16'd0 : stick_v;

	logic signed [16:0] dx_in, up_in;
	logic keep_in;
	always_comb begin
		if (s_tuser[0]) begin
			dx_in = 17'(signed'(u_f));
			up_in = -17'(signed'(v_f));
		end else begin
			dx_in = 17'(point_x) - 17'(center_x);
			up_in = 17'(center_y) - 17'(point_y);
		end
	end
	assign keep_in = s_tuser[0] && (u_f == 16'd0) && (v_f == 16'd0);

	// vectoring start: fold a negative up component by a half turn
	logic signed [17:0] x_init, y_init;
	assign x_init = up_q[16] ? -18'(up_q) : 18'(up_q);
	assign y_init = up_q[16] ? -18'(dx_q) : 18'(dx_q);

	// angle accumulator to 16-bit bearing and back
	logic [ANGLE_BITS-1:0] z_wrap;
	logic [15:0] bear_from_z;
	logic signed [ZW-1:0] z_from_bear;
	assign z_wrap = z_q[ANGLE_BITS-1:0];

	generate
		if (ANGLE_BITS > 16) begin : g_wide
			localparam int SH = ANGLE_BITS - 16;
			logic [ANGLE_BITS:0] rnd;
			assign rnd = {1'b0, z_wrap} + ({{ANGLE_BITS{1'b0}}, 1'b1} << (SH - 1));
			assign bear_from_z = rnd[SH +: 16];
			assign z_from_bear = ZW'(bear_q) << SH;
		end else begin : g_narrow
			assign bear_from_z = 16'(z_wrap) << (16 - ANGLE_BITS);
			assign z_from_bear = ZW'(bear_q >> (16 - ANGLE_BITS));
		end
	endgenerate

	// rotation start: bring the angle into +-quarter turn
	logic signed [ZW-1:0] z_sgn;
	assign z_sgn = (z_from_bear >= Z_HALF) ? z_from_bear - Z_FULL : z_from_bear;

	// shared CORDIC unit
	cordic_ctl_t ctl;
	logic signed [XY_W-1:0] x_nx, y_nx;
	logic signed [ZW-1:0] z_nx;
	assign ctl.rotate = (state_q == S_ROT);
	assign ctl.idx = IDX_W'(cnt_q);

	aboap_cordic_unit #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_cordic (
		.ctl (ctl),
		.x   (x_q),
		.y   (y_q),
		.z   (z_q),
		.x_nx(x_nx),
		.y_nx(y_nx),
		.z_nx(z_nx)
	);

	// final sign fix and round half up to Q.8
	logic signed [XY_W-1:0] xr, yr;
	assign xr = (rneg_q ? -x_q : x_q) + XY_W'(128);
	assign yr = (rneg_q ? -y_q : y_q) + XY_W'(128);

	logic [21:0] deg_full;
	assign deg_full = 22'(bear_q) * 22'd45;

	logic out_free;
	assign out_free = ~m_tvalid_q || m_tready;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= RADIUS_RESET;
			deadzone_q <= DEADZONE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ORBIT_RADIUS:   radius_q   <= wr_data[RADIUS_W-1:0];
				REG_STICK_DEADZONE: deadzone_q <= wr_data[DEADZONE_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			last_q     <= 16'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			// in S_OUT the valid flag is set below instead
			if (m_tvalid_q && m_tready && state_q != S_OUT)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q <= '0;
					if (keep_q || dx_q == 17'sd0)
						state_q <= S_ROTLOAD;
					else
						state_q <= S_VEC;
				end
				S_VEC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(N_STEPS - 1))
						state_q <= S_BEAR;
				end
				S_BEAR: state_q <= S_ROTLOAD;
				S_ROTLOAD: begin
					cnt_q <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(N_STEPS - 1))
						state_q <= S_FIN;
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						last_q <= bear_q;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				dx_q   <= dx_in;
				up_q   <= up_in;
				keep_q <= keep_in;
				cx_q   <= center_x;
				cy_q   <= center_y;
			end
			S_LOAD: begin
				prod_q <= 40'(radius_q) * 40'(GAIN_Q30);
				if (keep_q)
					bear_q <= last_q;
				else if (dx_q == 17'sd0)
					bear_q <= up_q[16] ? 16'h8000 : 16'h0000;
				x_q <= XY_W'(x_init) <<< 16;
				y_q <= XY_W'(y_init) <<< 16;
				z_q <= up_q[16] ? Z_HALF : '0;
			end
			S_VEC, S_ROT: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
			end
			S_BEAR: bear_q <= bear_from_z;
			S_ROTLOAD: begin
				x_q <= XY_W'(prod_q[39:14]);
				y_q <= '0;
				if (z_sgn > Z_QUARTER) begin
					z_q <= z_sgn - Z_HALF;
					rneg_q <= 1'b1;
				end else if (z_sgn < -Z_QUARTER) begin
					z_q <= z_sgn + Z_HALF;
					rneg_q <= 1'b1;
				end else begin
					z_q <= z_sgn;
					rneg_q <= 1'b0;
				end
			end
			S_FIN: begin
				c8_q <= xr[29:8];
				s8_q <= yr[29:8];
			end
			S_OUT: begin
				if (out_free) begin
					out_bear_q <= bear_q;
					out_deg_q  <= deg_full[21:7];
					out_px_q   <= 22'({cx_q, 8'd0}) + s8_q;
					out_py_q   <= 22'({cy_q, 8'd0}) - c8_q;
				end
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {5'd0, out_py_q, out_px_q, out_deg_q, out_bear_q};

endmodule

// ----- dv/tb_aim_bearing_and_orbit_point.sv -----
`timescale 1ns / 1ps

module tb_aim_bearing_and_orbit_point;
	import aboap_pkg::*;

	localparam int ANGLE_W = 16;
	localparam int CORDIC_N = 16;
	localparam int AIM_LATENCY = 2 * CORDIC_N + 5;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int WATCHDOG_CYCLES = 600000;
	localparam longint GAIN_Q30_TB = 64'd652032874;

	localparam logic AIM_POINTER = 1'b0;
	localparam logic AIM_STICK = 1'b1;

	typedef struct packed {
		logic [15:0] bearing;
		logic [14:0] degrees;
		logic [21:0] place_x;
		logic [21:0] place_y;
	} orbit_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [87:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [79:0] m_tdata;
	logic wr_en;
	logic [0:0] wr_index;
	logic [WR_DATA_W-1:0] wr_data;

	// arctangent of 2^-i, 2^32 per turn
	logic [31:0] arc_turn32 [0:15] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	logic [9:0] radius_px;
	logic [14:0] deadzone_q88;
	logic [15:0] held_bearing;

	orbit_result_t expected_orbit [$];
	orbit_result_t want;
	logic no_gaps;
	int hold_reqs;
	int mismatches;
	int n_results;
	int n_pointer;
	int n_stick;
	int n_holds;
	int n_writes;
	int cycles;

	aim_bearing_and_orbit_point #(
		.ANGLE_BITS(ANGLE_W),
		.CORDIC_STEPS(CORDIC_N)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic longint arc_step(input int i);
		return (longint'(arc_turn32[i]) + (longint'(1) << (31 - ANGLE_W))) >> (32 - ANGLE_W);
	endfunction

	// atan2(dx, up) as a binary angle; dx is nonzero
	function automatic logic [15:0] vector_bearing(input longint dx, input longint up);
		longint x, y, z, xs, ys;
		x = up * 65536;
		y = dx * 65536;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = longint'(1) << (ANGLE_W - 1);
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += arc_step(i);
			end else begin
				x -= ys;
				y += xs;
				z -= arc_step(i);
			end
		end
		// accumulator is already 16 bits per turn, so no rescale
		return z[15:0];
	endfunction

	function automatic void orbit_offset(input logic [15:0] b, output longint sin8,
			output longint cos8);
		longint x, y, z, xs, ys;
		logic flip;
		z = longint'(b);
		x = (longint'(radius_px) * GAIN_Q30_TB) >>> 14;
		y = 0;
		flip = 1'b0;
		if (z >= 32768)
			z -= 65536;
		if (z > 16384) begin
			z -= 32768;
			flip = 1'b1;
		end else if (z < -16384) begin
			z += 32768;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= arc_step(i);
			end else begin
				x += ys;
				y -= xs;
				z += arc_step(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cos8 = (x + 128) >>> 8;
		sin8 = (y + 128) >>> 8;
	endfunction

	function automatic orbit_result_t predict_aim(input logic action, input logic [12:0] px,
			input logic [12:0] py, input logic [15:0] su, input logic [15:0] sv,
			input logic [11:0] cx, input logic [11:0] cy);
		longint dx, up, u, v, sin8, cos8;
		logic [15:0] b;
		orbit_result_t r;
		if (action == AIM_STICK) begin
			u = longint'($signed(su));
			v = longint'($signed(sv));
			// deadzone is one-sided: only small positive values vanish
			if (u > 0 && u < longint'(deadzone_q88))
				u = 0;
			if (v > 0 && v < longint'(deadzone_q88))
				v = 0;
			dx = u;
			up = -v;
		end else begin
			dx = longint'($signed(px)) - longint'(cx);
			up = longint'(cy) - longint'($signed(py));
		end
		if (action == AIM_STICK && dx == 0 && up == 0) begin
			b = held_bearing;
			n_holds++;
		end else if (dx == 0) begin
			b = (up < 0) ? 16'd32768 : 16'd0;
		end else begin
			b = vector_bearing(dx, up);
		end
		held_bearing = b;
		orbit_offset(b, sin8, cos8);
		r.bearing = b;
		r.degrees = 15'((int'(b) * 45) >> 7);
		r.place_x = 22'(longint'(cx) * 256 + sin8);
		r.place_y = 22'(longint'(cy) * 256 - cos8);
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	task automatic send_aim(input logic action, input logic [12:0] px, input logic [12:0] py,
			input logic [15:0] su, input logic [15:0] sv, input logic [11:0] cx,
			input logic [11:0] cy);
		@(negedge clk);
		if (!no_gaps && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 45)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= action;
		s_tdata <= {6'b0, cy, cx, sv, su, py, px};
		do @(posedge clk); while (!s_tready);
		expected_orbit.push_back(predict_aim(action, px, py, su, sv, cx, cy));
		if (action == AIM_STICK)
			n_stick++;
		else
			n_pointer++;
	endtask

	// sender pause: nothing offered until every result is back
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_orbit.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] index, input logic [WR_DATA_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		if (index == REG_ORBIT_RADIUS)
			radius_px = value[9:0];
		else
			deadzone_q88 = value;
		n_writes++;
	endtask

	function automatic logic [15:0] rand_axis();
		logic [15:0] a;
		int d;
		d = int'(deadzone_q88);
		case ($urandom_range(0, 9))
			0, 1: a = 16'($urandom);
			2, 3, 4: a = 16'($urandom_range(0, 51200) - 25600);
			5, 6: a = 16'(int'($urandom_range(0, 2 * d + 4)) - (d + 2));
			7: a = 16'd0;
			8: a = 16'(d - int'($urandom_range(0, 1)));
			default: begin
				case ($urandom_range(0, 3))
					0: a = 16'h8000;
					1: a = 16'h7FFF;
					2: a = 16'(25600);
					default: a = 16'(-25600);
				endcase
			end
		endcase
		return a;
	endfunction

	function automatic logic [12:0] rand_coord(input logic [11:0] center);
		logic [12:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2: c = 13'($urandom);
			3: c = 13'(center);
			4, 5: c = 13'(int'(center) + int'($urandom_range(0, 64)) - 32);
			default: c = 13'($urandom_range(0, 4095));
		endcase
		return c;
	endfunction

	// ---------------- tests ----------------

	task automatic test_pointer_directions();
		send_aim(AIM_POINTER, 2048, 2048, 0, 0, 2048, 2048);     // on the center
		send_aim(AIM_POINTER, 100, 0, 0, 0, 100, 500);           // straight up
		send_aim(AIM_POINTER, 100, 900, 0, 0, 100, 500);         // straight down
		send_aim(AIM_POINTER, 600, 500, 0, 0, 100, 500);         // right
		send_aim(AIM_POINTER, -4096, 500, 0, 0, 4095, 500);      // far left
		send_aim(AIM_POINTER, 4095, -4096, 0, 0, 0, 0);          // upper right
		send_aim(AIM_POINTER, -4096, 4095, 0, 0, 4095, 0);       // lower left
		send_aim(AIM_POINTER, 4095, 4095, 0, 0, 0, 0);           // lower right
		send_aim(AIM_POINTER, 1, -4096, 0, 0, 0, 4095);          // just off vertical
	endtask

	task automatic test_stick_deadzone();
		send_aim(AIM_STICK, 0, 0, 0, 0, 1000, 3000);             // zero stick holds
		send_aim(AIM_STICK, 0, 0, 100, 0, 0, 4095);              // cleared by deadzone
		send_aim(AIM_STICK, 0, 0, 0, 127, 4095, 0);
		send_aim(AIM_STICK, 0, 0, -1, 0, 2000, 2000);            // negative passes
		send_aim(AIM_STICK, 0, 0, 128, 0, 2000, 2000);           // at deadzone passes
		send_aim(AIM_STICK, 0, 0, 0, -25600, 10, 20);
		send_aim(AIM_STICK, 0, 0, 0, 25600, 4095, 4095);
		send_aim(AIM_STICK, 0, 0, 16'h7FFF, 16'h8000, 300, 700);
		send_aim(AIM_STICK, 0, 0, 16'h8000, 16'h7FFF, 700, 300);
		send_aim(AIM_STICK, 0, 0, -25600, 100, 1234, 2345);
		send_aim(AIM_STICK, 0, 0, 25600, -1, 4000, 5);
	endtask

	task automatic test_register_extremes();
		wait_for_results();
		write_reg(REG_ORBIT_RADIUS, 15'd1023);
		write_reg(REG_STICK_DEADZONE, 15'd0);
		send_aim(AIM_STICK, 0, 0, 1, 0, 4095, 4095);
		send_aim(AIM_POINTER, 4095, -4096, 0, 0, 0, 4095);
		wait_for_results();
		write_reg(REG_ORBIT_RADIUS, 15'd0);
		send_aim(AIM_POINTER, 17, 3000, 0, 0, 2500, 1200);
		wait_for_results();
		// radius written at full port width, upper bits dropped
		write_reg(REG_ORBIT_RADIUS, 15'h7FFF);
		write_reg(REG_STICK_DEADZONE, 15'h7FFF);
		send_aim(AIM_STICK, 0, 0, 16'h7FFF, 25600, 0, 0);
		send_aim(AIM_STICK, 0, 0, 16'h8000, 32766, 4095, 0);
	endtask

	task automatic test_random_aim(input int count, input int stick_pct);
		logic [11:0] cx, cy;
		logic action;
		repeat (count) begin
			cx = 12'($urandom);
			cy = 12'($urandom);
			action = ($urandom_range(0, 99) < stick_pct) ? AIM_STICK : AIM_POINTER;
			send_aim(action, rand_coord(cx), rand_coord(cy), rand_axis(), rand_axis(), cx, cy);
		end
	endtask

	task automatic test_config_sweep();
		for (int phase = 0; phase < 8; phase++) begin
			wait_for_results();
			case (phase)
				0: begin
					write_reg(REG_ORBIT_RADIUS, 15'd1023);
					write_reg(REG_STICK_DEADZONE, 15'd0);
				end
				1: begin
					write_reg(REG_ORBIT_RADIUS, 15'd0);
					write_reg(REG_STICK_DEADZONE, 15'd25600);
				end
				2: begin
					write_reg(REG_ORBIT_RADIUS, 15'($urandom));
					write_reg(REG_STICK_DEADZONE, 15'($urandom));
				end
				default: begin
					write_reg(REG_ORBIT_RADIUS, 15'($urandom_range(0, 1023)));
					write_reg(REG_STICK_DEADZONE, 15'($urandom_range(0, 25600)));
				end
			endcase
			no_gaps = (phase == 3);
			test_random_aim(115, 20 + 10 * phase);
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_output_backpressure();
		wait_for_results();
		hold_reqs++;
		test_random_aim(24, 50);
		wait_for_results();
	endtask

	// ---------------- result side ----------------

	initial begin : sink
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_seen) begin
				hold_left = SINK_HOLD_CYCLES;
				hold_seen = hold_reqs;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!no_gaps && $urandom_range(0, 99) < 9) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		mismatches++;
		if (mismatches <= 40)
			$display("tb: %s mismatch at %0t ns: got %0d, expected %0d", what, $time, got,
				exp_val);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (expected_orbit.size() == 0) begin
				report_mismatch("unrequested result, bearing", m_tdata[15:0], -1);
			end else begin
				want = expected_orbit.pop_front();
				if (m_tdata[15:0] !== want.bearing)
					report_mismatch("bearing", m_tdata[15:0], want.bearing);
				if (m_tdata[30:16] !== want.degrees)
					report_mismatch("bearing_degrees", m_tdata[30:16], want.degrees);
				if (m_tdata[52:31] !== want.place_x)
					report_mismatch("place_x", $signed(m_tdata[52:31]), $signed(want.place_x));
				if (m_tdata[74:53] !== want.place_y)
					report_mismatch("place_y", $signed(m_tdata[74:53]), $signed(want.place_y));
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// ---------------- sequence ----------------

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		no_gaps = 1'b0;
		hold_reqs = 0;
		radius_px = 10'd75;
		deadzone_q88 = 15'd128;
		held_bearing = 16'd0;
		mismatches = 0;
		n_results = 0;
		n_pointer = 0;
		n_stick = 0;
		n_holds = 0;
		n_writes = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pointer_directions();
		test_stick_deadzone();
		test_register_extremes();
		test_config_sweep();
		test_output_backpressure();

		wait_for_results();
		repeat (AIM_LATENCY + 8) @(posedge clk);
		if (expected_orbit.size() != 0)
			report_mismatch("results outstanding", 0, expected_orbit.size());

		$display("tb: %0d pointer and %0d stick requests, %0d held bearings, %0d register writes",
			n_pointer, n_stick, n_holds, n_writes);
		$display("tb: %0d results compared, %0d mismatches", n_results, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
